FILE: src/shash_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shash_pkg: shared types and constants of the SHA-256 stream hasher
// Holds the round constants, initial hash values and the command and status
// structs that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package shash_pkg;

  localparam int unsigned NUM_ROUNDS = 64;
  localparam int unsigned NUM_WORDS  = 8;
  localparam logic [7:0]  PAD_MARK   = 8'h80;

  typedef logic [31:0] word_t;

  // Source of the byte shifted into the block buffer
  typedef enum logic [1:0] {
    SRC_IN   = 2'd0,
    SRC_MARK = 2'd1,
    SRC_ZERO = 2'd2,
    SRC_LEN  = 2'd3
  } byte_src_t;

  typedef struct packed {
    logic      shift;      // shift one byte into the block buffer
    byte_src_t src;        // where that byte comes from
    logic      count;      // count one message byte
    logic      load;       // copy hash words into working variables
    logic      round;      // run one compression round
    logic [5:0] round_idx; // round number
    logic      fold;       // add working variables into hash words
    logic      clear;      // return to the initial hash state
    logic [2:0] word_idx;  // digest word on the output
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] fill;      // bytes pending in the block buffer
  } dp_stat_t;

  localparam word_t HASH_INIT [NUM_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [NUM_ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage
`default_nettype wire

FILE: src/sha256_stream_hasher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_stream_hasher: byte-serial SHA-256 hasher
// Hashes a byte stream and transfers the eight digest words at message end.
// ----------------------------------------------------------------------------
// A message byte without a block boundary is taken without a stall. Filling the
// 64th byte of a block starts a compression (load, 64 rounds on one shared
// round unit, fold). At message end the controller shifts in the pad mark,
// zeros and the 64-bit length one byte per cycle, so finishing takes the
// padding shifts plus one or two compressions, then eight digest transfers,
// word 0 first, last_word set on word 7. The input stalls from message end
// until the last digest word has been taken.
module sha256_stream_hasher (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_byte_valid,
  input  wire logic        in_end_of_message,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_last_word
);

  shash_pkg::dp_cmd_t  cmd;
  shash_pkg::dp_stat_t stat;

  shash_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte_valid     (in_byte_valid),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .word_idx          (out_word_index),
    .cmd               (cmd),
    .stat              (stat)
  );

  shash_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_byte (in_data_byte),
    .cmd     (cmd),
    .stat    (stat),
    .digest  (out_digest_word)
  );

  assign out_last_word = (out_word_index == 3'd7);

  // Never take input while digest words are pending
  a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input open during digest transfer");

  // Final word transfer ends the output burst
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_word) |=> !out_valid)
    else $error("output continued after last word");

  // Word index advances by one on each transfer within a burst
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_word) |=>
    (out_valid && out_word_index == $past(out_word_index) + 3'd1))
    else $error("digest word index skipped");

endmodule
`default_nettype wire

FILE: src/shash_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shash_dp: SHA-256 datapath
// Block buffer as a byte shift line that doubles as the message schedule
// window, working variables with one round unit, hash words and counters.
// ----------------------------------------------------------------------------
module shash_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [7:0]        in_byte,
  input  wire shash_pkg::dp_cmd_t cmd,
  output shash_pkg::dp_stat_t    stat,
  output shash_pkg::word_t       digest
);

  logic [511:0]     buf_r;
  shash_pkg::word_t v_r [8];
  shash_pkg::word_t h_r [8];
  logic [5:0]       fill_r;
  logic [60:0]      len_r;

  shash_pkg::word_t win [16];
  shash_pkg::word_t w_new, s0, s1, bs0, bs1, ch, maj, t1, t2;
  logic [63:0]      bits;
  logic [7:0]       byte_sel;

  // Word 15 is the current schedule word w[t], word 0 is w[t+15]
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      win[i] = buf_r[32*i +: 32];
    end
  end

  // Schedule expansion
  always_comb begin
    s0 = ({win[14][6:0], win[14][31:7]}) ^ ({win[14][17:0], win[14][31:18]})
         ^ (win[14] >> 3);
    s1 = ({win[1][16:0], win[1][31:17]}) ^ ({win[1][18:0], win[1][31:19]})
         ^ (win[1] >> 10);
    w_new = win[15] + s0 + win[6] + s1;
  end

  // Round function
  always_comb begin
    bs1 = ({v_r[4][5:0], v_r[4][31:6]}) ^ ({v_r[4][10:0], v_r[4][31:11]})
          ^ ({v_r[4][24:0], v_r[4][31:25]});
    ch  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1  = v_r[7] + bs1 + ch + shash_pkg::ROUND_K[cmd.round_idx] + win[15];
    bs0 = ({v_r[0][1:0], v_r[0][31:2]}) ^ ({v_r[0][12:0], v_r[0][31:13]})
          ^ ({v_r[0][21:0], v_r[0][31:22]});
    maj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2  = bs0 + maj;
  end

  // Select the byte to shift in; length bytes go out most significant first
  always_comb begin
    bits = {len_r, 3'b000};
    unique case (cmd.src)
      shash_pkg::SRC_IN:   byte_sel = in_byte;
      shash_pkg::SRC_MARK: byte_sel = shash_pkg::PAD_MARK;
      shash_pkg::SRC_ZERO: byte_sel = 8'h00;
      shash_pkg::SRC_LEN:  byte_sel = bits[(6'd63 - {fill_r[2:0], 3'b000}) -: 8];
      default:             byte_sel = 8'h00;
    endcase
  end

  // Buffer and working variables
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      buf_r <= {buf_r[503:0], byte_sel};
    end else if (cmd.round) begin
      buf_r <= {buf_r[479:0], w_new};
    end
    if (cmd.load) begin
      v_r <= h_r;
    end else if (cmd.round) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  // Hash words and counters
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      h_r    <= shash_pkg::HASH_INIT;
      fill_r <= '0;
      len_r  <= '0;
    end else begin
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) begin
          h_r[i] <= h_r[i] + v_r[i];
        end
      end
      if (cmd.shift) begin
        fill_r <= fill_r + 6'd1;
      end
      if (cmd.count) begin
        len_r <= len_r + 61'd1;
      end
    end
  end

  assign stat.fill = fill_r;
  assign digest    = h_r[cmd.word_idx];

endmodule
`default_nettype wire

FILE: src/shash_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shash_ctrl: SHA-256 controller
// Sequences byte intake, padding, the 64 compression rounds and the
// transfer of the eight digest words.
// ----------------------------------------------------------------------------
module shash_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_byte_valid,
  input  wire logic               in_end_of_message,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              word_idx,
  output shash_pkg::dp_cmd_t      cmd,
  input  wire shash_pkg::dp_stat_t stat
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MARK, ST_ZERO, ST_LEN, ST_START, ST_ROUND, ST_FOLD, ST_OUT
  } state_t;

  state_t     state_r, state_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       pad_r, pad_nxt;    // message end seen
  logic       mark_r, mark_nxt;  // pad mark already placed
  logic       last_r, last_nxt;  // length block loaded
  logic       acc;

  assign acc      = in_valid && (state_r == ST_IDLE);
  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign word_idx  = idx_r;

  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = rnd_r;
    idx_nxt   = idx_r;
    pad_nxt   = pad_r;
    mark_nxt  = mark_r;
    last_nxt  = last_r;
    cmd       = '0;
    cmd.src   = shash_pkg::SRC_IN;
    cmd.round_idx = rnd_r;
    cmd.word_idx  = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (in_byte_valid) begin
            cmd.shift = 1'b1;
            cmd.count = 1'b1;
          end
          if (in_byte_valid && stat.fill == 6'd63) begin
            pad_nxt   = in_end_of_message;
            state_nxt = ST_START;
          end else if (in_end_of_message) begin
            pad_nxt   = 1'b1;
            state_nxt = ST_MARK;
          end
        end
      end
      ST_MARK: begin
        cmd.shift = 1'b1;
        cmd.src   = shash_pkg::SRC_MARK;
        mark_nxt  = 1'b1;
        if (stat.fill == 6'd63) begin
          state_nxt = ST_START;
        end else if (stat.fill == 6'd55) begin
          state_nxt = ST_LEN;
        end else begin
          state_nxt = ST_ZERO;
        end
      end
      ST_ZERO: begin
        cmd.shift = 1'b1;
        cmd.src   = shash_pkg::SRC_ZERO;
        if (stat.fill == 6'd63) begin
          state_nxt = ST_START;
        end else if (stat.fill == 6'd55) begin
          state_nxt = ST_LEN;
        end
      end
      ST_LEN: begin
        cmd.shift = 1'b1;
        cmd.src   = shash_pkg::SRC_LEN;
        if (stat.fill == 6'd63) begin
          last_nxt  = 1'b1;
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        cmd.load  = 1'b1;
        rnd_nxt   = '0;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        rnd_nxt   = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd.fold = 1'b1;
        idx_nxt  = '0;
        priority if (!pad_r) begin
          state_nxt = ST_IDLE;
        end else if (last_r) begin
          state_nxt = ST_OUT;
        end else if (!mark_r) begin
          state_nxt = ST_MARK;
        end else begin
          state_nxt = ST_ZERO;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            cmd.clear = 1'b1;
            pad_nxt   = 1'b0;
            mark_nxt  = 1'b0;
            last_nxt  = 1'b0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold state and sequencing registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rnd_r   <= '0;
      idx_r   <= '0;
      pad_r   <= 1'b0;
      mark_r  <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
      idx_r   <= idx_nxt;
      pad_r   <= pad_nxt;
      mark_r  <= mark_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: verif/tb_sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// tb_sha256_stream_hasher: self-checking bench for the SHA-256 stream hasher
// Drives byte streams split into messages, predicts each digest in the bench
// and compares the eight digest words of every message field by field.
// ----------------------------------------------------------------------------
module tb_sha256_stream_hasher;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_item_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_byte_valid;
  logic        in_end_of_message;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  msg_item_t    pending_items[$];
  digest_item_t expected_digests[$];

  // Hashing state of the predictor
  shash_pkg::word_t hash_acc [shash_pkg::NUM_WORDS];
  logic [7:0]  blk_buf [64];
  int unsigned blk_fill;
  logic [60:0] msg_len;

  int     mismatches;
  int     cycle_count;
  int     burst_left;
  int     gap_left;
  int     hold_left;
  bit     hold_done;

  sha256_stream_hasher u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_byte_valid    (in_byte_valid),
    .in_end_of_message(in_end_of_message),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_digest_word  (out_digest_word),
    .out_word_index   (out_word_index),
    .out_last_word    (out_last_word)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic shash_pkg::word_t rotr(shash_pkg::word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Run one compression over the block buffer
  function automatic void compress_blk();
    shash_pkg::word_t w [64];
    shash_pkg::word_t v [8];
    shash_pkg::word_t s0, s1, t1, t2;
    for (int t = 0; t < 16; t++) begin
      w[t] = {blk_buf[4*t], blk_buf[4*t+1], blk_buf[4*t+2], blk_buf[4*t+3]};
    end
    for (int t = 16; t < 64; t++) begin
      s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = hash_acc[i];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + shash_pkg::ROUND_K[t] + w[t];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_acc[i] += v[i];
  endfunction

  function automatic void restart_hash();
    for (int i = 0; i < 8; i++) hash_acc[i] = shash_pkg::HASH_INIT[i];
    for (int i = 0; i < 64; i++) blk_buf[i] = 8'h00;
    blk_fill = 0;
    msg_len  = '0;
  endfunction

  // Absorb one accepted item and queue the digest on message end
  function automatic void absorb_item(msg_item_t it);
    logic [63:0] bit_len;
    digest_item_t d;
    if (it.byte_valid) begin
      blk_buf[blk_fill] = it.data_byte;
      blk_fill++;
      msg_len++;
      if (blk_fill == 64) begin
        compress_blk();
        blk_fill = 0;
      end
    end
    if (!it.end_of_message) return;
    bit_len = {msg_len, 3'b000};
    blk_buf[blk_fill] = shash_pkg::PAD_MARK;
    for (int i = blk_fill + 1; i < 64; i++) blk_buf[i] = 8'h00;
    if (blk_fill > 55) begin
      compress_blk();
      for (int i = 0; i < 64; i++) blk_buf[i] = 8'h00;
    end
    for (int k = 0; k < 8; k++) blk_buf[56+k] = bit_len[63-8*k -: 8];
    compress_blk();
    for (int k = 0; k < 8; k++) begin
      d.digest_word = hash_acc[k];
      d.word_index  = 3'(k);
      d.last_word   = (k == 7);
      expected_digests.push_back(d);
    end
    restart_hash();
  endfunction

  function automatic void add_msg(int len, bit end_with_byte);
    msg_item_t it;
    for (int i = 0; i < len; i++) begin
      it.data_byte  = 8'($urandom);
      it.byte_valid = 1'b1;
      it.end_of_message = end_with_byte && (i == len - 1);
      // scatter ignored items inside the message
      if ($urandom_range(0, 15) == 0) pending_items.push_back('{8'($urandom), 1'b0, 1'b0});
      pending_items.push_back(it);
    end
    if (!end_with_byte || len == 0)
      pending_items.push_back('{8'($urandom), 1'b0, 1'b1});
  endfunction

  // Sender: bursts of transfers with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_items.size() > 0) begin
        {in_data_byte, in_byte_valid, in_end_of_message} <= pending_items[0];
        absorb_item(pending_items.pop_front());
        in_valid <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: own stall pattern plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left > 1);
    end else if (!hold_done && out_valid) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (cycle_count % 300 < 150) ? 1'b0 : ($urandom_range(0, 3) == 0);
    end
  end

  // Monitor: compare each digest transfer with the oldest expectation
  always @(posedge clk) begin
    digest_item_t want;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_digests.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected digest word %h index %0d", out_digest_word, out_word_index);
      end else begin
        want = expected_digests.pop_front();
        if (want != {out_digest_word, out_word_index, out_last_word}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h/%0d/%b got %h/%0d/%b", want.digest_word,
                     want.word_index, want.last_word, out_digest_word,
                     out_word_index, out_last_word);
        end
      end
    end
  end

  initial begin
    int lengths[$];
    mismatches = 0;
    cycle_count = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = 8'h00;
    in_byte_valid = 1'b0;
    in_end_of_message = 1'b0;
    out_stall = 1'b0;
    restart_hash();
    // Directed: empty message, ignored item, bytes 00/ff with end on ff, then abc closed by a separate end item
    pending_items.push_back('{8'h5a, 1'b0, 1'b1});
    pending_items.push_back('{8'ha5, 1'b0, 1'b0});
    pending_items.push_back('{8'h00, 1'b1, 1'b0});
    pending_items.push_back('{8'hff, 1'b1, 1'b1});
    pending_items.push_back('{8'h61, 1'b1, 1'b0});
    pending_items.push_back('{8'h62, 1'b1, 1'b0});
    pending_items.push_back('{8'h63, 1'b1, 1'b0});
    pending_items.push_back('{8'h00, 1'b0, 1'b1});
    // Padding boundaries: 55 bytes fit one final block, 56 need two
    lengths = '{55, 56};
    foreach (lengths[i]) add_msg(lengths[i], $urandom_range(0, 1));
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_items.size() == 0);
    @(posedge clk);
    wait (!(in_valid && in_stall));
    @(posedge clk);
    wait (expected_digests.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_digests.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Timeout guard
  always @(posedge clk) begin
    if (cycle_count > 300000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule
